/* rtl/core/sobel_edge_magnitude_rgb_top_assert.svh */
// Assertion macros shared by the edge magnitude design.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in edge magnitude block.");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in edge magnitude block.");

`endif

/* rtl/core/sem_pkg.sv */
`timescale 1ns / 1ps

package sem_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 24;
    localparam int SUM_W  = 21;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = 12;
    localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [8:0][CH_W-1:0] chan_win_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
    } root_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_SHIFT,
        ST_GRAD,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/sem_line_store.sv */
`timescale 1ns / 1ps

module sem_line_store #(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [2*sem_pkg::PIX_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [2*sem_pkg::PIX_W-1:0] wr_data
);

    logic [2*sem_pkg::PIX_W-1:0] line_mem_reg [MAX_WIDTH];
    logic [2*sem_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/sem_grad.sv */
`timescale 1ns / 1ps

module sem_grad (
    input  sem_pkg::chan_win_t          v,
    output logic [sem_pkg::SUM_W-1:0]   sum
);

    logic signed [11:0] e [9];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic signed [23:0] sq_x;
    logic signed [23:0] sq_y;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            e[i] = $signed({4'b0000, v[i]});
        end
        gx = -e[0] + e[2] - (e[3] <<< 1) + (e[5] <<< 1) - e[6] + e[8];
        gy = -e[0] - (e[1] <<< 1) - e[2] + e[6] + (e[7] <<< 1) + e[8];
        sq_x = gx * gx;
        sq_y = gy * gy;
        sum = sq_x[sem_pkg::SUM_W-1:0] + sq_y[sem_pkg::SUM_W-1:0];
    end

endmodule

/* rtl/core/sem_root.sv */
`timescale 1ns / 1ps

module sem_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sem_pkg::root_req_t          req,
    output logic                        done,
    output logic [sem_pkg::CH_W-1:0]    result
);

    logic [sem_pkg::SUM_W-1:0] s_reg;
    logic [sem_pkg::CH_W-1:0]  m_reg;
    logic [sem_pkg::CH_W-1:0]  m_next;
    logic [2:0]                k_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [sem_pkg::CH_W-1:0]  trial;
    logic [16:0]               t;

    always_comb
    begin
        trial  = m_reg | (8'd1 << k_reg);
        t      = 17'(trial) * 17'(trial) + 17'(trial);
        m_next = (sem_pkg::SUM_W'(t) < s_reg) ? trial : m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 3'd7;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == 3'd0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 3'd7;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            s_reg <= req.sum;
            m_reg <= '0;
        end
        else if (busy_reg)
        begin
            m_reg <= m_next;
        end
    end

    assign done   = done_reg;
    assign result = (s_reg > sem_pkg::SAT_LIMIT) ? 8'd255 :
                    (s_reg == '0) ? 8'd0 : m_reg + 8'd1;

endmodule

/* rtl/core/sobel_edge_magnitude_rgb_top.sv */
`timescale 1ns / 1ps

// Per-channel 3x3 Sobel magnitude over a raster RGB stream, with two line stores in one
// synchronous memory. A result passes through the eight-step iterative root, and the extra
// result at the last column needs one more window shift first. The input is stalled while
// an item is in work. A result waits in the output register while the next item is taken.

`include "sobel_edge_magnitude_rgb_top_assert.svh"

module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  edge_red,
    output logic [7:0]  edge_green,
    output logic [7:0]  edge_blue,
    output logic        last_in_step,
    output logic        end_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > sem_pkg::CFG_W) ? WW : sem_pkg::CFG_W;

    sem_pkg::state_t state_reg, state_next;

    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;
    logic [AW-1:0]             col_reg;
    logic [sem_pkg::ROW_W-1:0] row_reg;

    logic [AW-1:0]             c_reg;
    logic [sem_pkg::ROW_W-1:0] r_reg;
    logic                      r_is_h_reg;
    logic                      first_reg;
    logic                      second_reg;
    logic                      pass_reg;
    sem_pkg::pix_t             p_reg;
    sem_pkg::pix_t             win_reg [9];

    logic                      out_valid_reg;
    logic [7:0]                edge_red_reg;
    logic [7:0]                edge_green_reg;
    logic [7:0]                edge_blue_reg;
    logic                      last_reg;
    logic                      eof_reg;

    logic [EW-1:0]             w_ext;
    logic [EW-1:0]             w_eff;
    logic [EW-1:0]             c_ext;
    logic [EW-1:0]             c_eff;
    logic [sem_pkg::ROW_W-1:0] h_eff;
    logic [sem_pkg::ROW_W-1:0] r_eff;
    logic                      is_last;
    logic                      in_accept;
    logic                      cfg_write;

    logic [2*sem_pkg::PIX_W-1:0] rd_data;
    logic                        mem_wr;
    sem_pkg::pix_t               col_a;
    sem_pkg::pix_t               col_b;

    sem_pkg::chan_win_t          win_ch [3];
    logic [sem_pkg::SUM_W-1:0]   sum_ch [3];
    logic [7:0]                  mag_ch [3];
    logic [2:0]                  done_ch;
    logic                        grad_start;
    logic                        emit_load;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext == '0)
        begin
            w_eff = EW'(1);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        c_ext   = EW'(col_reg);
        c_eff   = (c_ext >= w_eff) ? (w_eff - EW'(1)) : c_ext;
        is_last = (c_eff == w_eff - EW'(1));
        h_eff   = (height_reg == '0) ? sem_pkg::ROW_W'(1) : height_reg;
        r_eff   = (row_reg > h_eff) ? h_eff : row_reg;
    end

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sem_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[sem_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sem_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            sem_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = sem_pkg::ST_WIN;
                end
            end
            sem_pkg::ST_WIN:
            begin
                if (first_reg)
                begin
                    state_next = sem_pkg::ST_GRAD;
                end
                else if (second_reg)
                begin
                    state_next = sem_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            sem_pkg::ST_SHIFT: state_next = sem_pkg::ST_GRAD;
            sem_pkg::ST_GRAD:  state_next = sem_pkg::ST_ROOT;
            sem_pkg::ST_ROOT:
            begin
                if (done_ch[0])
                begin
                    state_next = sem_pkg::ST_EMIT;
                end
            end
            sem_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = (!pass_reg && second_reg) ? sem_pkg::ST_SHIFT
                                                           : sem_pkg::ST_IDLE;
                end
            end
            default: state_next = sem_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        mem_wr     = 1'b0;
        grad_start = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_IDLE: in_stall   = 1'b0;
            sem_pkg::ST_WIN:  mem_wr     = 1'b1;
            sem_pkg::ST_GRAD: grad_start = 1'b1;
            sem_pkg::ST_EMIT: emit_load  = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                if (is_last)
                begin
                    col_reg <= '0;
                    row_reg <= (r_eff >= h_eff) ? '0 : r_eff + sem_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= AW'(c_eff + EW'(1));
                    row_reg <= r_eff;
                end
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            c_reg      <= c_eff[AW-1:0];
            r_reg      <= r_eff;
            r_is_h_reg <= (r_eff == h_eff);
            first_reg  <= (r_eff != '0) && (c_eff != '0);
            second_reg <= (r_eff != '0) && is_last;
            pass_reg   <= 1'b0;
            p_reg      <= (kind || r_eff >= h_eff) ? '0 : {red, green, blue};
        end
        else if (state_reg == sem_pkg::ST_SHIFT)
        begin
            pass_reg <= 1'b1;
        end
    end

    assign col_a = (r_reg >= sem_pkg::ROW_W'(2)) ? rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W]
                                                : '0;
    assign col_b = (r_reg >= sem_pkg::ROW_W'(1)) ? rd_data[sem_pkg::PIX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (state_reg == sem_pkg::ST_WIN)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[3*i]   <= (c_reg == '0) ? '0 : win_reg[3*i+1];
                win_reg[3*i+1] <= (c_reg == '0) ? '0 : win_reg[3*i+2];
            end
            win_reg[2] <= col_a;
            win_reg[5] <= col_b;
            win_reg[8] <= p_reg;
        end
        else if (state_reg == sem_pkg::ST_SHIFT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[3*i]   <= win_reg[3*i+1];
                win_reg[3*i+1] <= win_reg[3*i+2];
                win_reg[3*i+2] <= '0;
            end
        end
    end

    sem_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (c_eff[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (mem_wr),
        .wr_addr (c_reg),
        .wr_data ({col_b, p_reg})
    );

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_ch[0][k] = win_reg[k][23:16];
            win_ch[1][k] = win_reg[k][15:8];
            win_ch[2][k] = win_reg[k][7:0];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        sem_pkg::root_req_t req;

        sem_grad u_grad (
            .v   (win_ch[g]),
            .sum (sum_ch[g])
        );

        assign req.start = grad_start;
        assign req.sum   = sum_ch[g];

        sem_root u_root (
            .clk    (clk),
            .rst_n  (rst_n),
            .req    (req),
            .done   (done_ch[g]),
            .result (mag_ch[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            edge_red_reg   <= mag_ch[0];
            edge_green_reg <= mag_ch[1];
            edge_blue_reg  <= mag_ch[2];
            last_reg       <= pass_reg || !second_reg;
            eof_reg        <= pass_reg && r_is_h_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign edge_red     = edge_red_reg;
    assign edge_green   = edge_green_reg;
    assign edge_blue    = edge_blue_reg;
    assign last_in_step = last_reg;
    assign end_of_frame = eof_reg;

    `SEM_ASSERT_NEXT(a_accept_to_win, clk, rst_n, in_accept, state_reg == sem_pkg::ST_WIN)
    `SEM_ASSERT_SAME(a_roots_in_step, clk, rst_n, 1'b1,
        (done_ch[0] == done_ch[1]) && (done_ch[1] == done_ch[2]))
    `SEM_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, emit_load, out_valid_reg)
    `SEM_ASSERT_NEXT(a_shift_to_grad, clk, rst_n, state_reg == sem_pkg::ST_SHIFT,
        state_reg == sem_pkg::ST_GRAD && pass_reg)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       last_in_step;
        logic       end_of_frame;
    } edge_item_t;

    localparam int MAXW = 2048;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  edge_red;
    logic [7:0]  edge_green;
    logic [7:0]  edge_blue;
    logic        last_in_step;
    logic        end_of_frame;

    sobel_edge_magnitude_rgb_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_item_t pending_pixels[$];
    edge_item_t  expected_edges[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          quiet_cycles;
    bit          hold_sender;

    logic [11:0] model_width;
    logic [11:0] model_height;
    logic [23:0] older_row[MAXW];
    logic [23:0] newer_row[MAXW];
    logic [23:0] window[9];
    int          model_row;
    int          model_col;

    function automatic logic [7:0] channel_edge(int sh);
        int v[9];
        int gx;
        int gy;
        int s;
        int n;
        for (int i = 0; i < 9; i++)
        begin
            v[i] = (window[i] >> sh) & 255;
        end
        gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
        gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
        s = gx * gx + gy * gy;
        if (s > 255 * 255 + 255)
        begin
            return 8'd255;
        end
        n = 0;
        while (n * n + n < s)
        begin
            n++;
        end
        return n[7:0];
    endfunction

    task automatic shift_column(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
        for (int i = 0; i < 3; i++)
        begin
            window[i * 3] = window[i * 3 + 1];
            window[i * 3 + 1] = window[i * 3 + 2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = bot;
    endtask

    task automatic push_edge(logic eof, bit last);
        edge_item_t e;
        e.edge_red = channel_edge(16);
        e.edge_green = channel_edge(8);
        e.edge_blue = channel_edge(0);
        e.last_in_step = last;
        e.end_of_frame = eof;
        expected_edges.push_back(e);
    endtask

    task automatic predict_edges(pixel_item_t it);
        int w;
        int h;
        int r;
        int c;
        logic [23:0] p;
        logic [23:0] a;
        logic [23:0] b;
        bit last;
        w = model_width;
        h = model_height;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        if (h < 1) h = 1;
        c = model_col;
        if (c >= w) c = w - 1;
        r = model_row;
        if (r > h) r = h;
        p = (it.kind || r >= h) ? 24'd0 : {it.red, it.green, it.blue};
        a = (r >= 2) ? older_row[c] : 24'd0;
        b = (r >= 1) ? newer_row[c] : 24'd0;
        older_row[c] = b;
        newer_row[c] = p;
        if (c == 0)
        begin
            for (int i = 0; i < 9; i++) window[i] = 24'd0;
        end
        shift_column(a, b, p);
        last = (c == w - 1);
        if (r >= 1 && c >= 1)
        begin
            push_edge(1'b0, !(r >= 1 && last));
        end
        if (r >= 1 && last)
        begin
            shift_column(24'd0, 24'd0, 24'd0);
            push_edge(r == h, 1'b1);
        end
        if (last)
        begin
            model_col = 0;
            model_row = (r >= h) ? 0 : r + 1;
        end
        else
        begin
            model_col = c + 1;
            model_row = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            red <= 8'd0;
            green <= 8'd0;
            blue <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_edges({kind, red, green, blue});
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pixels.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_item_t it;
                    it = pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    {kind, red, green, blue} <= it;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_edges.size() == 0)
                begin
                    $error("unexpected result item");
                    error_count++;
                end
                else
                begin
                    edge_item_t e;
                    e = expected_edges.pop_front();
                    if (edge_red !== e.edge_red)
                    begin
                        $error("edge_red expected %0d got %0d", e.edge_red, edge_red);
                        error_count++;
                    end
                    if (edge_green !== e.edge_green)
                    begin
                        $error("edge_green expected %0d got %0d", e.edge_green, edge_green);
                        error_count++;
                    end
                    if (edge_blue !== e.edge_blue)
                    begin
                        $error("edge_blue expected %0d got %0d", e.edge_blue, edge_blue);
                        error_count++;
                    end
                    if (last_in_step !== e.last_in_step)
                    begin
                        $error("last_in_step expected %0d got %0d", e.last_in_step,
                               last_in_step);
                        error_count++;
                    end
                    if (end_of_frame !== e.end_of_frame)
                    begin
                        $error("end_of_frame expected %0d got %0d", e.end_of_frame,
                               end_of_frame);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || in_valid || expected_edges.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_frame(int w, int h);
        write_reg(3'(4 * sem_pkg::REG_IMAGE_WIDTH), 32'(w));
        write_reg(3'(4 * sem_pkg::REG_IMAGE_HEIGHT), 32'(h));
        model_width = 12'(w);
        model_height = 12'(h);
    endtask

    task automatic queue_frame(int w, int h, int mode);
        pixel_item_t it;
        int ew;
        int eh;
        ew = (w < 1) ? 1 : w;
        eh = (h < 1) ? 1 : h;
        for (int i = 0; i < ew * (eh + 1); i++)
        begin
            it.kind = (i >= ew * eh) ? 1'b1 : ($urandom_range(19) == 0);
            case (mode)
                0: it[23:0] = 24'hFFFFFF;
                1: it[23:0] = ((i / ew + i) % 2) ? 24'hFFFFFF : 24'h000000;
                default: it[23:0] = 24'($urandom);
            endcase
            if (i >= ew * eh && $urandom_range(1)) it[23:0] = 24'($urandom);
            pending_pixels.push_back(it);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        hold_sender = 1'b0;
        model_width = 12'd640;
        model_height = 12'd480;
        model_row = 0;
        model_col = 0;
        for (int i = 0; i < 9; i++) window[i] = 24'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        set_frame(1, 1);
        queue_frame(1, 1, 2);
        wait_drained();
        set_frame(3, 3);
        queue_frame(3, 3, 0);
        wait_drained();
        set_frame(4, 2);
        queue_frame(4, 2, 1);
        wait_drained();
        set_frame(0, 0);
        queue_frame(0, 0, 2);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            int w;
            int h;
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 50; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 50; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == 7)
            begin
                w = 640;
                h = 1;
            end
            else
            begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 12);
            end
            set_frame(w, h);
            queue_frame(w, h, 2);
            if (phase == 3)
            begin
                queue_frame(w, h, 2);
                while (pending_pixels.size() > w * (h + 1)) @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_edges.size() > 0) @(posedge clk);
                repeat (5) @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_line_store.sv
rtl/core/sem_grad.sv
rtl/core/sem_root.sv
rtl/core/sobel_edge_magnitude_rgb_top.sv
sim/tb_top.sv
